FILE: src/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

	// Register stages in one fixed-point multiplier
	localparam int unsigned LAT_MUL = 4;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_INV_CELL_SIZE_SQ = 2'd0,
		CFG_TIME_STEP        = 2'd1,
		CFG_IMPLICIT_WEIGHT  = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

FILE: src/tss_fmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Sign-magnitude fixed-point multiply: four half-width partial products,
// middle-term add, full add with rounding, then saturation to the word.
module tss_fmul #(
	parameter int MW = 48,
	parameter int W  = 48,
	parameter int F  = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          a_neg,
	input  wire logic [MW-1:0] a_mag,
	input  wire logic          b_neg,
	input  wire logic [MW-1:0] b_mag,
	output logic      [W-1:0]  p,
	output logic               ov
);
	import tss_pkg::*;

	localparam int H  = (MW + 1) / 2;
	localparam int SW = 4 * H + 1;
	localparam int PW = SW - F;
	localparam logic [SW-1:0] RND = SW'(1) << (F - 1);
	localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

	logic [2*H-1:0] a_ext, b_ext;
	logic [2*H-1:0] a_lo, a_hi, b_lo, b_hi;
	logic [2*H-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [2*H:0]   mid_s2;
	logic [4*H-1:0] hl_cat_s2;
	logic [SW-1:0]  sum_s3;
	logic           neg_s [1:LAT_MUL-1];
	logic [PW-1:0]  shifted;
	logic           ov_pos, ov_neg;
	logic [W-1:0]   p_s4;
	logic           ov_s4;

	assign a_ext = (2*H)'(a_mag);
	assign b_ext = (2*H)'(b_mag);

	// Widen the halves to the product width
	assign a_lo = (2*H)'(a_ext[H-1:0]);
	assign a_hi = (2*H)'(a_ext[2*H-1:H]);
	assign b_lo = (2*H)'(b_ext[H-1:0]);
	assign b_hi = (2*H)'(b_ext[2*H-1:H]);

	// Partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1    <= a_lo * b_lo;
			lh_s1    <= a_lo * b_hi;
			hl_s1    <= a_hi * b_lo;
			hh_s1    <= a_hi * b_hi;
			neg_s[1] <= a_neg ^ b_neg;
		end
	end

	// Combine the cross terms
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s2    <= {1'b0, lh_s1} + {1'b0, hl_s1};
			hl_cat_s2 <= {hh_s1, ll_s1};
			neg_s[2]  <= neg_s[1];
		end
	end

	// Full product plus half an LSB of the result
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3   <= SW'(hl_cat_s2) + (SW'(mid_s2) << H) + RND;
			neg_s[3] <= neg_s[2];
		end
	end

	assign shifted = sum_s3[SW-1:F];
	assign ov_pos  = |shifted[PW-1:W-1];
	assign ov_neg  = (|shifted[PW-1:W]) | (shifted[W-1] & (|shifted[W-2:0]));

	// Saturate to the word range
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[LAT_MUL-1]) begin
				p_s4  <= ov_neg ? W_MIN : W'(0) - shifted[W-1:0];
				ov_s4 <= ov_neg;
			end else begin
				p_s4  <= ov_pos ? W_MAX : shifted[W-1:0];
				ov_s4 <= ov_pos;
			end
		end
	end

	assign p  = p_s4;
	assign ov = ov_s4;

endmodule

`default_nettype wire

FILE: src/tss_fdiv.sv
`timescale 1ns / 1ps
`default_nettype none

// Rounded quotient (num << F) / den, one quotient bit per stage.
// Quotients that do not fit the word are caught up front and saturate.
module tss_fdiv #(
	parameter int W = 48,
	parameter int F = 32
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-2:0] num,
	input  wire logic [W-2:0] den,
	output logic      [W-1:0] q,
	output logic              ov
);
	localparam int NW = W + F;
	localparam int CW = (F + 1 > W - 1) ? F + 1 : W - 1;
	localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};

	logic [NW-1:0] n_s1;
	logic [W-2:0]  den_s1;
	logic [F:0]    n_hi;

	logic [W-1:0]  rem_s [0:W-1];
	logic [W-2:0]  low_s [0:W-1];
	logic [W-2:0]  quo_s [0:W-1];
	logic [W-2:0]  den_s [0:W-1];
	logic          sat_s [0:W-1];
	logic [W-1:0]  trial [1:W-1];
	logic          take  [1:W-1];

	logic [W-1:0]  q_q;
	logic          ov_q;

	// Scaled numerator with half the divisor added for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= (NW'(num) << F) + NW'(den >> 1);
			den_s1 <= den;
		end
	end

	assign n_hi = n_s1[NW-1:W-1];

	// Overflow check and first partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= CW'(n_hi) >= CW'(den_s1);
			rem_s[0] <= W'(n_hi);
			low_s[0] <= n_s1[W-2:0];
			quo_s[0] <= '0;
			den_s[0] <= den_s1;
		end
	end

	// Trial subtraction for each step
	always_comb begin
		for (int j = 1; j < W; j++) begin
			trial[j] = {rem_s[j-1][W-2:0], low_s[j-1][W-2]};
			take[j]  = trial[j] >= {1'b0, den_s[j-1]};
		end
	end

	// Advance the restoring steps
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 1; j < W; j++) begin
				rem_s[j] <= take[j] ? trial[j] - {1'b0, den_s[j-1]} : trial[j];
				low_s[j] <= {low_s[j-1][W-3:0], 1'b0};
				quo_s[j] <= {quo_s[j-1][W-3:0], take[j]};
				den_s[j] <= den_s[j-1];
				sat_s[j] <= sat_s[j-1];
			end
		end
	end

	// Saturate
	always_ff @(posedge clk) begin
		if (en) begin
			q_q  <= sat_s[W-1] ? W_MAX : {1'b0, quo_s[W-1]};
			ov_q <= sat_s[W-1];
		end
	end

	assign q  = q_q;
	assign ov = ov_q;

endmodule

`default_nettype wire

FILE: src/theta_scheme_stencil_row_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Five-point theta-scheme stencil row generator.
// Input channel (in_valid / in_stall) carries one grid cell per transaction:
// storativity, four interface transmissivities, five heads and a source or
// fixed value. Output channel (out_valid / out_stall) carries the row: centre
// and four neighbour coefficients, right-hand side and three status flags.
// All numbers are signed fixed point, FRAC_BITS fraction bits in WORD_BITS.
// The cfg_we / cfg_index / cfg_data port writes the three settings; write
// them only while no transaction is in flight.
// The divider for dt / S sets most of the depth from acceptance to out_valid;
// it produces one quotient bit per stage and is followed by two rounds of
// four-stage multipliers. Throughput is one cell per cycle while the receiver
// does not stall: every stage takes a new cell each clock.
// When the receiver stalls, the output register holds and the whole pipeline
// freezes together with in_stall raised; nothing is dropped or repeated.
// Reset empties the pipeline and loads 1.0, 1.0 and 0.5 into the settings.
module theta_scheme_stencil_row_core #(
	parameter int WORD_BITS = 48,
	parameter int FRAC_BITS = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [tss_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [((WORD_BITS-1 > FRAC_BITS+1) ?
		WORD_BITS-1 : FRAC_BITS+1)-1:0]                cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  fixed_cell,
	input  wire logic [WORD_BITS-2:0]                  storativity,
	input  wire logic [WORD_BITS-2:0]                  trans_east,
	input  wire logic [WORD_BITS-2:0]                  trans_west,
	input  wire logic [WORD_BITS-2:0]                  trans_north,
	input  wire logic [WORD_BITS-2:0]                  trans_south,
	input  wire logic signed [WORD_BITS-1:0]           head_center,
	input  wire logic signed [WORD_BITS-1:0]           head_east,
	input  wire logic signed [WORD_BITS-1:0]           head_west,
	input  wire logic signed [WORD_BITS-1:0]           head_north,
	input  wire logic signed [WORD_BITS-1:0]           head_south,
	input  wire logic signed [WORD_BITS-1:0]           source_or_fixed,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [WORD_BITS-1:0]                coef_center,
	output logic signed [WORD_BITS-1:0]                coef_east,
	output logic signed [WORD_BITS-1:0]                coef_west,
	output logic signed [WORD_BITS-1:0]                coef_north,
	output logic signed [WORD_BITS-1:0]                coef_south,
	output logic signed [WORD_BITS-1:0]                rhs,
	output logic                                       was_fixed,
	output logic                                       overflow,
	output logic                                       zero_storage
);
	import tss_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int MW = (W > F) ? W : F + 1;

	typedef logic [W-1:0] word_t;

	localparam logic [MW:0] ONE_W  = (MW+1)'(1) << F;
	localparam logic [MW:0] HALF_W = (MW+1)'(1) << (F - 1);
	localparam word_t W_MAX   = {1'b0, {(W-1){1'b1}}};
	localparam word_t W_MIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic  ONE_OV  = (F > W - 2);
	localparam word_t ONE_SAT = ONE_OV ? W_MAX : ONE_W[W-1:0];

	// Pipeline timing, in stages from the input register
	localparam int T_IN = 1;
	localparam int T_D  = T_IN + LAT_MUL;
	localparam int T_DS = T_D + 3;
	localparam int T_P  = T_D + LAT_MUL;
	localparam int T_HC = T_DS + LAT_MUL;
	localparam int T_FX = T_HC + 1;
	localparam int T_G  = T_IN + W + 2;
	localparam int T_K  = T_G + LAT_MUL;
	localparam int T_E  = T_K + LAT_MUL;
	localparam int T_C  = T_E + 1;
	localparam int T_OUT = T_C + 1;

	// Saturating add and subtract, flag in the top bit
	function automatic logic [W:0] sat_add(word_t a, word_t b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return {1'b1, s[W] ? W_MIN : W_MAX};
		end
		return {1'b0, s[W-1:0]};
	endfunction

	function automatic logic [W:0] sat_sub(word_t a, word_t b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return {1'b1, s[W] ? W_MIN : W_MAX};
		end
		return {1'b0, s[W-1:0]};
	endfunction

	// Split a word into sign and magnitude
	function automatic logic [MW:0] to_sm(word_t v);
		word_t m;
		m = v[W-1] ? W'(0) - v : v;
		return {v[W-1], MW'(m)};
	endfunction

	logic en;

	// Settings
	logic [W-2:0] inv_q, ts_q;
	logic [F:0]   theta_q;
	logic [F:0]   theta_c, omt;

	// Input register
	logic [W-2:0] tr_s1 [0:3];
	logic [W-2:0] stor_s1;

	// Carried fields
	logic  v_s   [T_IN:T_OUT];
	logic  fix_s [T_IN:T_C];
	logic  zs_s  [T_IN:T_C];
	word_t hc_s  [T_IN:T_C];
	word_t src_s [T_IN:T_C];
	word_t h_s   [0:3][T_IN:T_D];
	logic  ov_s  [T_IN:T_C];
	logic [T_C-1:T_IN] add_ov;

	// Interim results
	word_t d_m [0:3];
	logic  dov [0:3];
	word_t d_s [0:3][T_D+1:T_K];
	word_t ds1_s, ds2_s;
	word_t dsum_s [T_DS:T_K];
	word_t p_m [0:3];
	logic  pov [0:3];
	word_t f1_s, f2_s, f3_s, p2_s;
	word_t p3_s [T_P+1:T_P+2];
	word_t dshc_m;
	logic  dshc_ov;
	word_t flux_s [T_FX:T_K];
	word_t g_m;
	logic  g_ov;
	word_t k_m, ge_m, gq_m;
	logic  k_ov, ge_ov, gq_ov;
	word_t gq_s [T_K+1:T_C];
	word_t kd_m [0:3];
	logic  kd_ov [0:3];
	word_t kds_m, gef_m;
	logic  kds_ov, gef_ov;
	word_t cn_s [0:3];
	word_t c0_s, r1_s;

	logic [W:0] ds1_r, ds2_r, dsum_r, f1_r, f2_r, f3_r, flux_r, c0_r, r1_r, rhs_r;
	logic [MW:0] g_sm, k_sm, ge_sm, dsum_sm, flux_sm, src_sm, hc_sm;
	logic [MW:0] d_sm [0:3];
	logic [MW:0] h_sm [0:3];
	logic [MW:0] dk_sm [0:3];

	// Output register
	logic  out_v_unused;
	word_t coef_center_q, rhs_q;
	word_t coef_nb_q [0:3];
	logic  was_fixed_q, overflow_q, zero_storage_q;
	logic  comp;

	assign en        = !v_s[T_OUT] || !out_stall;
	assign in_stall  = !en;
	assign out_valid = v_s[T_OUT];
	assign out_v_unused = 1'b0;

	// Hold the settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q   <= ONE_W[W-2:0];
			ts_q    <= ONE_W[W-2:0];
			theta_q <= HALF_W[F:0];
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_INV_CELL_SIZE_SQ: inv_q   <= cfg_data[W-2:0];
				CFG_TIME_STEP:        ts_q    <= cfg_data[W-2:0];
				CFG_IMPLICIT_WEIGHT:  theta_q <= cfg_data[F:0];
				default: ;
			endcase
		end
	end

	// Clamp the weight to one
	assign theta_c = (theta_q > ONE_W[F:0]) ? ONE_W[F:0] : theta_q;
	assign omt     = ONE_W[F:0] - theta_c;

	// Advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = T_IN; t <= T_OUT; t++) begin
				v_s[t] <= 1'b0;
			end
		end else if (en) begin
			v_s[T_IN] <= in_valid;
			for (int t = T_IN + 1; t <= T_OUT; t++) begin
				v_s[t] <= v_s[t-1];
			end
		end
	end

	// Capture the cell and carry its fields along
	always_ff @(posedge clk) begin
		if (en) begin
			tr_s1[0] <= trans_east;
			tr_s1[1] <= trans_west;
			tr_s1[2] <= trans_north;
			tr_s1[3] <= trans_south;
			stor_s1  <= storativity;
			fix_s[T_IN] <= fixed_cell;
			zs_s[T_IN]  <= (storativity == '0);
			hc_s[T_IN]  <= head_center;
			src_s[T_IN] <= source_or_fixed;
			h_s[0][T_IN] <= head_east;
			h_s[1][T_IN] <= head_west;
			h_s[2][T_IN] <= head_north;
			h_s[3][T_IN] <= head_south;
			ov_s[T_IN]  <= 1'b0;
			for (int t = T_IN + 1; t <= T_C; t++) begin
				fix_s[t] <= fix_s[t-1];
				zs_s[t]  <= zs_s[t-1];
				hc_s[t]  <= hc_s[t-1];
				src_s[t] <= src_s[t-1];
				ov_s[t]  <= ov_s[t-1] | add_ov[t-1];
			end
			for (int i = 0; i < 4; i++) begin
				for (int t = T_IN + 1; t <= T_D; t++) begin
					h_s[i][t] <= h_s[i][t-1];
				end
			end
		end
	end

	// Conductances d = T / dx^2, then d * h for the flux and k * d for the neighbours
	for (genvar i = 0; i < 4; i++) begin : g_nb
		assign d_sm[i] = to_sm(d_m[i]);
		assign h_sm[i] = to_sm(h_s[i][T_D]);
		assign dk_sm[i] = to_sm(d_s[i][T_K]);

		tss_fmul #(.MW(MW), .W(W), .F(F)) u_d (
			.clk(clk), .en(en),
			.a_neg(1'b0), .a_mag(MW'(tr_s1[i])),
			.b_neg(1'b0), .b_mag(MW'(inv_q)),
			.p(d_m[i]), .ov(dov[i])
		);

		tss_fmul #(.MW(MW), .W(W), .F(F)) u_dh (
			.clk(clk), .en(en),
			.a_neg(d_sm[i][MW]), .a_mag(d_sm[i][MW-1:0]),
			.b_neg(h_sm[i][MW]), .b_mag(h_sm[i][MW-1:0]),
			.p(p_m[i]), .ov(pov[i])
		);

		tss_fmul #(.MW(MW), .W(W), .F(F)) u_kd (
			.clk(clk), .en(en),
			.a_neg(k_sm[MW]), .a_mag(k_sm[MW-1:0]),
			.b_neg(dk_sm[i][MW]), .b_mag(dk_sm[i][MW-1:0]),
			.p(kd_m[i]), .ov(kd_ov[i])
		);
	end

	// Sum of conductances and running flux sum
	assign ds1_r  = sat_add(d_m[0], d_m[1]);
	assign ds2_r  = sat_add(ds1_s, d_s[2][T_D+1]);
	assign dsum_r = sat_add(ds2_s, d_s[3][T_D+2]);
	assign f1_r   = sat_add(p_m[0], p_m[1]);
	assign f2_r   = sat_add(f1_s, p2_s);
	assign f3_r   = sat_add(f2_s, p3_s[T_P+2]);
	assign flux_r = sat_sub(f3_s, dshc_m);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				d_s[i][T_D+1] <= d_m[i];
				for (int t = T_D + 2; t <= T_K; t++) begin
					d_s[i][t] <= d_s[i][t-1];
				end
			end
			ds1_s <= ds1_r[W-1:0];
			ds2_s <= ds2_r[W-1:0];
			dsum_s[T_DS] <= dsum_r[W-1:0];
			for (int t = T_DS + 1; t <= T_K; t++) begin
				dsum_s[t] <= dsum_s[t-1];
			end
			f1_s <= f1_r[W-1:0];
			p2_s <= p_m[2];
			p3_s[T_P+1] <= p_m[3];
			p3_s[T_P+2] <= p3_s[T_P+1];
			f2_s <= f2_r[W-1:0];
			f3_s <= f3_r[W-1:0];
			flux_s[T_FX] <= flux_r[W-1:0];
			for (int t = T_FX + 1; t <= T_K; t++) begin
				flux_s[t] <= flux_s[t-1];
			end
		end
	end

	// Centre head times conductance sum
	assign dsum_sm = to_sm(dsum_s[T_DS]);
	assign hc_sm   = to_sm(hc_s[T_DS]);

	tss_fmul #(.MW(MW), .W(W), .F(F)) u_dshc (
		.clk(clk), .en(en),
		.a_neg(dsum_sm[MW]), .a_mag(dsum_sm[MW-1:0]),
		.b_neg(hc_sm[MW]), .b_mag(hc_sm[MW-1:0]),
		.p(dshc_m), .ov(dshc_ov)
	);

	// g = dt / S
	tss_fdiv #(.W(W), .F(F)) u_div (
		.clk(clk), .en(en),
		.num(ts_q), .den(stor_s1),
		.q(g_m), .ov(g_ov)
	);

	assign g_sm   = to_sm(g_m);
	assign src_sm = to_sm(src_s[T_G]);

	tss_fmul #(.MW(MW), .W(W), .F(F)) u_k (
		.clk(clk), .en(en),
		.a_neg(1'b0), .a_mag(MW'(theta_c)),
		.b_neg(g_sm[MW]), .b_mag(g_sm[MW-1:0]),
		.p(k_m), .ov(k_ov)
	);

	tss_fmul #(.MW(MW), .W(W), .F(F)) u_ge (
		.clk(clk), .en(en),
		.a_neg(1'b0), .a_mag(MW'(omt)),
		.b_neg(g_sm[MW]), .b_mag(g_sm[MW-1:0]),
		.p(ge_m), .ov(ge_ov)
	);

	tss_fmul #(.MW(MW), .W(W), .F(F)) u_gq (
		.clk(clk), .en(en),
		.a_neg(g_sm[MW]), .a_mag(g_sm[MW-1:0]),
		.b_neg(src_sm[MW]), .b_mag(src_sm[MW-1:0]),
		.p(gq_m), .ov(gq_ov)
	);

	// Implicit and explicit products
	assign k_sm    = to_sm(k_m);
	assign ge_sm   = to_sm(ge_m);
	assign flux_sm = to_sm(flux_s[T_K]);

	tss_fmul #(.MW(MW), .W(W), .F(F)) u_kds (
		.clk(clk), .en(en),
		.a_neg(k_sm[MW]), .a_mag(k_sm[MW-1:0]),
		.b_neg(1'b0), .b_mag(MW'(dsum_s[T_K])),
		.p(kds_m), .ov(kds_ov)
	);

	tss_fmul #(.MW(MW), .W(W), .F(F)) u_gef (
		.clk(clk), .en(en),
		.a_neg(ge_sm[MW]), .a_mag(ge_sm[MW-1:0]),
		.b_neg(flux_sm[MW]), .b_mag(flux_sm[MW-1:0]),
		.p(gef_m), .ov(gef_ov)
	);

	// Coefficients and first part of the right-hand side
	assign c0_r = sat_add(ONE_SAT, kds_m);
	assign r1_r = sat_add(hc_s[T_E], gef_m);

	always_ff @(posedge clk) begin
		if (en) begin
			gq_s[T_K+1] <= gq_m;
			for (int t = T_K + 2; t <= T_C; t++) begin
				gq_s[t] <= gq_s[t-1];
			end
			for (int i = 0; i < 4; i++) begin
				cn_s[i] <= W'(0) - kd_m[i];
			end
			c0_s <= c0_r[W-1:0];
			r1_s <= r1_r[W-1:0];
		end
	end

	// Collect saturation flags at the stage where each arises
	always_comb begin
		add_ov = '0;
		add_ov[T_D]    = add_ov[T_D] | dov[0] | dov[1] | dov[2] | dov[3] | ds1_r[W];
		add_ov[T_D+1]  = add_ov[T_D+1] | ds2_r[W];
		add_ov[T_D+2]  = add_ov[T_D+2] | dsum_r[W];
		add_ov[T_P]    = add_ov[T_P] | pov[0] | pov[1] | pov[2] | pov[3] | f1_r[W];
		add_ov[T_P+1]  = add_ov[T_P+1] | f2_r[W];
		add_ov[T_P+2]  = add_ov[T_P+2] | f3_r[W];
		add_ov[T_HC]   = add_ov[T_HC] | dshc_ov | flux_r[W];
		add_ov[T_G]    = add_ov[T_G] | g_ov;
		add_ov[T_K]    = add_ov[T_K] | k_ov | ge_ov | gq_ov;
		add_ov[T_E]    = add_ov[T_E] | kd_ov[0] | kd_ov[1] | kd_ov[2] | kd_ov[3]
			| kds_ov | gef_ov | c0_r[W] | r1_r[W];
	end

	// Final right-hand side and row selection
	assign rhs_r = sat_add(r1_s, gq_s[T_C]);
	assign comp  = !fix_s[T_C] && !zs_s[T_C];

	always_ff @(posedge clk) begin
		if (en) begin
			was_fixed_q    <= fix_s[T_C];
			zero_storage_q <= !fix_s[T_C] && zs_s[T_C];
			overflow_q     <= ONE_OV | (comp & (ov_s[T_C] | rhs_r[W] | out_v_unused));
			if (comp) begin
				coef_center_q <= c0_s;
				rhs_q         <= rhs_r[W-1:0];
				for (int i = 0; i < 4; i++) begin
					coef_nb_q[i] <= cn_s[i];
				end
			end else begin
				coef_center_q <= ONE_SAT;
				rhs_q         <= fix_s[T_C] ? src_s[T_C] : hc_s[T_C];
				for (int i = 0; i < 4; i++) begin
					coef_nb_q[i] <= '0;
				end
			end
		end
	end

	assign coef_center  = coef_center_q;
	assign coef_east    = coef_nb_q[0];
	assign coef_west    = coef_nb_q[1];
	assign coef_north   = coef_nb_q[2];
	assign coef_south   = coef_nb_q[3];
	assign rhs          = rhs_q;
	assign was_fixed    = was_fixed_q;
	assign overflow     = overflow_q;
	assign zero_storage = zero_storage_q;

	// An accepted cell enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s[T_IN])
		else $error("accepted cell missing from first stage");

	// A row is never both a boundary row and a zero-storage row
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_fixed && zero_storage))
		else $error("row marked both fixed and zero storage");

	// Identity rows carry no neighbour coupling
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (was_fixed || zero_storage)) |->
		(coef_east == '0 && coef_west == '0 && coef_north == '0 && coef_south == '0))
		else $error("identity row with neighbour coefficient");

	// Neighbour coefficients are never positive (checked on east and south)
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((coef_east[W-1] || coef_east == '0) &&
			(coef_south[W-1] || coef_south == '0)))
		else $error("positive neighbour coefficient");

endmodule

`default_nettype wire

FILE: tb/theta_scheme_stencil_row_core_tb.sv
`timescale 1ns / 1ps

module theta_scheme_stencil_row_core_tb;
	import tss_pkg::*;

	localparam int W = 48;
	localparam int F = 32;
	localparam longint WMAX = (64'sd1 <<< (W - 1)) - 1;
	localparam longint WMIN = -WMAX - 1;
	localparam longint ONE = 64'sd1 <<< F;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = W + 20;

	typedef struct packed {
		logic             fixed;
		logic [W-2:0]     stor;
		logic [3:0][W-2:0] tr;   // east, west, north, south
		logic [3:0][W-1:0] hd;   // east, west, north, south
		logic [W-1:0]     hc;
		logic [W-1:0]     src;
	} cell_t;

	typedef struct packed {
		logic [4:0][W-1:0] coef; // centre, east, west, north, south
		logic [W-1:0]      rhs;
		logic              wf;
		logic              ov;
		logic              zs;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [W-2:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	cell_t cur = '0;
	logic signed [W-1:0] coef_center, coef_east, coef_west, coef_north, coef_south, rhs;
	logic was_fixed, overflow, zero_storage;

	// settings as the block should hold them
	logic [W-2:0] sh_inv = 47'(ONE);
	logic [W-2:0] sh_dt = 47'(ONE);
	logic [F:0]   sh_theta = 33'(ONE / 2);

	cell_t pending_cells[$];
	row_t  expected_rows[$];
	int errors = 0;
	int accepted_cells = 0;
	int cycles = 0;

	theta_scheme_stencil_row_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.fixed_cell(cur.fixed), .storativity(cur.stor),
		.trans_east(cur.tr[0]), .trans_west(cur.tr[1]),
		.trans_north(cur.tr[2]), .trans_south(cur.tr[3]),
		.head_center(cur.hc), .head_east(cur.hd[0]), .head_west(cur.hd[1]),
		.head_north(cur.hd[2]), .head_south(cur.hd[3]), .source_or_fixed(cur.src),
		.out_valid(out_valid), .out_stall(out_stall),
		.coef_center(coef_center), .coef_east(coef_east), .coef_west(coef_west),
		.coef_north(coef_north), .coef_south(coef_south), .rhs(rhs),
		.was_fixed(was_fixed), .overflow(overflow), .zero_storage(zero_storage)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fixed-point helpers
	function automatic longint clamp_mag(bit neg, logic [127:0] m, inout bit ov);
		if (neg) begin
			if (m > 128'(64'd1 << (W - 1))) begin
				ov = 1'b1;
				return WMIN;
			end
			return -longint'(m[63:0]);
		end
		if (m > 128'(WMAX)) begin
			ov = 1'b1;
			return WMAX;
		end
		return longint'(m[63:0]);
	endfunction

	function automatic longint qmul(longint a, longint b, inout bit ov);
		logic [127:0] ma, mb, p;
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		p = (ma * mb + (128'd1 << (F - 1))) >> F;
		return clamp_mag((a < 0) != (b < 0), p, ov);
	endfunction

	function automatic longint qadd(longint a, longint b, inout bit ov);
		longint s;
		s = a + b;
		if (s > WMAX) begin
			ov = 1'b1;
			return WMAX;
		end
		if (s < WMIN) begin
			ov = 1'b1;
			return WMIN;
		end
		return s;
	endfunction

	// Expected stencil row for one cell under the current settings
	function automatic row_t stencil_row(cell_t x);
		row_t r;
		bit ov;
		longint theta, g, k, ge, dsum, flux, hc, c;
		longint d[4];
		logic [127:0] n;
		r = '0;
		ov = 1'b0;
		hc = longint'($signed(x.hc));
		r.coef[0] = W'(ONE);
		if (x.fixed) begin
			r.rhs = x.src;
			r.wf = 1'b1;
		end else if (x.stor == 0) begin
			r.rhs = x.hc;
			r.zs = 1'b1;
		end else begin
			theta = (longint'(sh_theta) > ONE) ? ONE : longint'(sh_theta);
			for (int i = 0; i < 4; i++)
				d[i] = qmul(longint'(x.tr[i]), longint'(sh_inv), ov);
			n = (128'(sh_dt) << F) + 128'(x.stor >> 1);
			g = clamp_mag(1'b0, n / 128'(x.stor), ov);
			k = qmul(theta, g, ov);
			ge = qmul(ONE - theta, g, ov);
			dsum = 0;
			for (int i = 0; i < 4; i++) begin
				c = -qmul(k, d[i], ov);
				r.coef[i + 1] = c[W-1:0];
				dsum = qadd(dsum, d[i], ov);
			end
			c = qadd(ONE, qmul(k, dsum, ov), ov);
			r.coef[0] = c[W-1:0];
			flux = 0;
			for (int i = 0; i < 4; i++)
				flux = qadd(flux, qmul(d[i], longint'($signed(x.hd[i])), ov), ov);
			flux = qadd(flux, -qmul(dsum, hc, ov), ov);
			c = qadd(hc, qmul(ge, flux, ov), ov);
			c = qadd(c, qmul(g, longint'($signed(x.src)), ov), ov);
			r.rhs = c[W-1:0];
		end
		r.ov = ov;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [W-1:0] any_word();
		return W'({$urandom, $urandom});
	endfunction

	function automatic logic [W-1:0] mid_word();
		logic [W-1:0] v;
		v = W'($urandom) | (W'($urandom_range(0, 15)) << 32);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic cell_t random_cell();
		cell_t x;
		int mode;
		mode = $urandom_range(0, 99);
		x.fixed = (mode < 10);
		for (int i = 0; i < 4; i++) begin
			x.tr[i] = (mode < 30) ? (W - 1)'(any_word()) :
				(W - 1)'($urandom) << $urandom_range(0, 3);
			x.hd[i] = (mode < 30) ? any_word() : mid_word();
		end
		x.hc = (mode < 30) ? any_word() : mid_word();
		x.src = (mode < 30) ? any_word() : mid_word();
		if (mode >= 10 && mode < 15)
			x.stor = '0;
		else if (mode < 30)
			x.stor = (W - 1)'(any_word());
		else
			x.stor = (W - 1)'($urandom_range(1, 32'hffffffff)) << $urandom_range(0, 6);
		return x;
	endfunction

	task automatic report(string what, logic [W-1:0] got, logic [W-1:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch on %s: got %h, expected %h", what, got, want);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [W-2:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_INV_CELL_SIZE_SQ: sh_inv = v;
			CFG_TIME_STEP: sh_dt = v;
			default: sh_theta = v[F:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cells.size() != 0 || in_valid || expected_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_all(logic [W-2:0] inv, logic [W-2:0] dt, logic [W-2:0] th);
		write_reg(CFG_INV_CELL_SIZE_SQ, inv);
		write_reg(CFG_TIME_STEP, dt);
		write_reg(CFG_IMPLICIT_WEIGHT, th);
	endtask

	// Driver: offer pending cells with random gaps, log each accepted transaction
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (in_valid) begin
				expected_rows.push_back(stencil_row(cur));
				accepted_cells++;
			end
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_cells.size() != 0) begin
				cur <= pending_cells.pop_front();
				in_valid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure, one long hold-off, compare each row
	int out_gap = 0;
	int long_hold = 0;
	bit held = 1'b0;
	always @(posedge clk) begin
		row_t want;
		if (out_valid && !out_stall) begin
			if (expected_rows.size() == 0) begin
				report("unexpected row", coef_center, '0);
			end else begin
				want = expected_rows.pop_front();
				if (coef_center !== want.coef[0]) report("coef_center", coef_center, want.coef[0]);
				if (coef_east !== want.coef[1]) report("coef_east", coef_east, want.coef[1]);
				if (coef_west !== want.coef[2]) report("coef_west", coef_west, want.coef[2]);
				if (coef_north !== want.coef[3]) report("coef_north", coef_north, want.coef[3]);
				if (coef_south !== want.coef[4]) report("coef_south", coef_south, want.coef[4]);
				if (rhs !== want.rhs) report("rhs", rhs, want.rhs);
				if (was_fixed !== want.wf) report("was_fixed", W'(was_fixed), W'(want.wf));
				if (overflow !== want.ov) report("overflow", W'(overflow), W'(want.ov));
				if (zero_storage !== want.zs) report("zero_storage", W'(zero_storage), W'(want.zs));
			end
		end
		if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1'b1;
		end else if (!held && accepted_cells >= 150) begin
			held = 1'b1;
			long_hold = 400;
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 99) < 20) out_gap = pick_gap();
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		cell_t x;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed cells under reset settings
		x = '0;
		x.fixed = 1'b1;
		x.src = {1'b0, {(W - 1){1'b1}}};
		pending_cells.push_back(x);
		x.src = {1'b1, {(W - 1){1'b0}}};
		x.stor = '1;
		pending_cells.push_back(x);
		x = '0;
		x.hc = {1'b1, {(W - 1){1'b0}}};
		pending_cells.push_back(x);   // zero storativity
		x.hc = '1;
		x.tr = '1;
		pending_cells.push_back(x);
		x = '0;
		x.stor = 47'(ONE);
		for (int i = 0; i < 4; i++) begin
			x.tr[i] = 47'(ONE);
			x.hd[i] = W'(ONE * (i + 2));
		end
		x.hc = W'(ONE);
		x.src = W'(ONE / 2);
		pending_cells.push_back(x);   // plain case
		x.stor = 47'd1;
		pending_cells.push_back(x);   // g saturates
		x.stor = '1;
		pending_cells.push_back(x);
		x.tr = '1;
		for (int i = 0; i < 4; i++) x.hd[i] = {1'b0, {(W - 1){1'b1}}};
		x.hc = {1'b1, {(W - 1){1'b0}}};
		x.src = {1'b1, {(W - 1){1'b0}}};
		x.stor = 47'(ONE);
		pending_cells.push_back(x);   // transmissivities, heads and source at their extremes
		for (int i = 0; i < 4; i++) x.hd[i] = {1'b1, {(W - 1){1'b0}}};
		x.hc = {1'b0, {(W - 1){1'b1}}};
		pending_cells.push_back(x);
		for (int i = 0; i < 8; i++) pending_cells.push_back(random_cell());
		for (int i = 0; i < 80; i++) pending_cells.push_back(random_cell());
		wait_drained();

		// sweep the settings, extremes first
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_all('1, '1, 47'(ONE));
				1: set_all('0, '0, '0);
				2: set_all(47'(ONE * 4), 47'(ONE / 8), 47'h1_ffff_ffff); // weight above one
				3: set_all(47'(ONE), 47'(ONE), 47'(ONE / 2));
				default: set_all(47'($urandom) << $urandom_range(0, 8),
					47'($urandom) << $urandom_range(0, 8), 47'($urandom));
			endcase
			for (int i = 0; i < 75; i++) pending_cells.push_back(random_cell());
			wait_drained();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
